@@ design/grid_occupancy_test_and_set_macros.svh @@
// Assertion macros for the grid occupancy test-and-set block.
`ifndef GRID_OCCUPANCY_TEST_AND_SET_MACROS_SVH
`define GRID_OCCUPANCY_TEST_AND_SET_MACROS_SVH
`ifndef SYNTHESIS
`define GOT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("grid occupancy assertion failed");
`define GOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid occupancy assertion failed");
`else
`define GOT_ASSERT(lbl, prop)
`define GOT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/got_pkg.sv @@
// Shared types and constants of the grid occupancy test-and-set block.
package got_pkg;

  localparam int unsigned GRID_CELLS_DEF = 32;
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned SCALE_W        = 31;
  localparam int unsigned CELL_W         = 5;
  localparam int unsigned REG_IDX_W      = 3;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
  localparam logic [CELL_W-1:0]  CLAMP_LOW_RST  = '0;
  localparam logic [CELL_W-1:0]  CLAMP_HIGH_RST = '1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_CLAMP_LOW,
    REG_CLAMP_HIGH
  } reg_idx_e;

  // Clamped cell span of one point.
  typedef struct packed {
    logic [CELL_W-1:0] xmn;
    logic [CELL_W-1:0] xmx;
    logic [CELL_W-1:0] ymn;
    logic [CELL_W-1:0] ymx;
    logic [CELL_W-1:0] zmn;
    logic [CELL_W-1:0] zmx;
  } span_t;

  // Status of the cell walker.
  typedef struct packed {
    logic idle;
    logic done;
    logic hit;
  } walk_st_t;

endpackage

@@ design/got_span.sv @@
// Cell span unit: per-axis (point - origin) * scale, floor/ceil and clamp.
module got_span (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [got_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [got_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [got_pkg::COORD_W-1:0]    point_z_i,
  input  logic signed [got_pkg::COORD_W-1:0]    origin_x_i,
  input  logic signed [got_pkg::COORD_W-1:0]    origin_y_i,
  input  logic signed [got_pkg::COORD_W-1:0]    origin_z_i,
  input  logic        [got_pkg::SCALE_W-1:0]    scale_x_i,
  input  logic        [got_pkg::SCALE_W-1:0]    scale_y_i,
  input  logic        [got_pkg::SCALE_W-1:0]    scale_z_i,
  input  logic        [got_pkg::CELL_W-1:0]     lo_i,
  input  logic        [got_pkg::CELL_W-1:0]     hi_i,
  output logic                                  done_o,
  output got_pkg::span_t                        span_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_RND} state_e;
  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_e;

  state_e state_q;
  axis_e  axis_q;
  logic   half_q;
  logic   done_q;

  logic signed [49:0] pp_q, pp_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] pp_ext;
  got_pkg::span_t     span_q;

  logic signed [got_pkg::COORD_W-1:0] pt, org;
  logic        [got_pkg::SCALE_W-1:0] scl;
  logic signed [32:0]                 diff;
  logic        [15:0]                 half_scl;
  logic signed [32:0]                 fl, ce;
  logic        [got_pkg::CELL_W-1:0]  fl_c, ce_c;

  function automatic logic [got_pkg::CELL_W-1:0] clamp_cell(
    input logic signed [32:0]           v,
    input logic [got_pkg::CELL_W-1:0]   lo,
    input logic [got_pkg::CELL_W-1:0]   hi
  );
    logic signed [32:0] c;
    logic signed [32:0] lo_s;
    logic signed [32:0] hi_s;
    lo_s = $signed({{(33 - got_pkg::CELL_W){1'b0}}, lo});
    hi_s = $signed({{(33 - got_pkg::CELL_W){1'b0}}, hi});
    c = v;
    if (c < lo_s) c = lo_s;
    if (c > hi_s) c = hi_s;
    return c[got_pkg::CELL_W-1:0];
  endfunction

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        pt = point_x_i; org = origin_x_i; scl = scale_x_i;
      end
      AXIS_Y: begin
        pt = point_y_i; org = origin_y_i; scl = scale_y_i;
      end
      default: begin
        pt = point_z_i; org = origin_z_i; scl = scale_z_i;
      end
    endcase
    diff     = {pt[31], pt} - {org[31], org};
    // scale is split in two halves to keep the multiplier narrow
    half_scl = half_q ? {1'b0, scl[30:16]} : scl[15:0];
    pp_d     = diff * $signed({1'b0, half_scl});
    pp_ext   = {{14{pp_q[49]}}, pp_q};
    acc_d    = half_q ? acc_q + {pp_ext[47:0], 16'b0} : pp_ext;
    fl       = {acc_q[63], acc_q[63:32]};
    ce       = fl + {32'b0, |acc_q[31:0]};
    fl_c     = clamp_cell(fl, lo_i, hi_i);
    ce_c     = clamp_cell(ce, lo_i, hi_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= AXIS_X;
      half_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_MUL;
            axis_q  <= AXIS_X;
            half_q  <= 1'b0;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (half_q) begin
            state_q <= S_RND;
          end else begin
            half_q  <= 1'b1;
            state_q <= S_MUL;
          end
        end
        S_RND: begin
          half_q <= 1'b0;
          case (axis_q)
            AXIS_X: begin
              axis_q  <= AXIS_Y;
              state_q <= S_MUL;
            end
            AXIS_Y: begin
              axis_q  <= AXIS_Z;
              state_q <= S_MUL;
            end
            default: begin
              axis_q  <= AXIS_X;
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) pp_q <= pp_d;
    if (state_q == S_ACC) acc_q <= acc_d;
    if (state_q == S_RND) begin
      case (axis_q)
        AXIS_X: begin
          span_q.xmn <= fl_c; span_q.xmx <= ce_c;
        end
        AXIS_Y: begin
          span_q.ymn <= fl_c; span_q.ymx <= ce_c;
        end
        default: begin
          span_q.zmn <= fl_c; span_q.zmx <= ce_c;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign span_o = span_q;

endmodule

@@ design/got_walk.sv @@
// Cell walker: read-modify-write of the occupancy memory over an xy span.
module got_walk #(
  parameter int unsigned GridCells = got_pkg::GRID_CELLS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  got_pkg::span_t   span_i,
  output got_pkg::walk_st_t st_o
);

  localparam int unsigned CW    = $clog2(GridCells);
  localparam int unsigned Depth = GridCells * GridCells;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [AW-1:0] RowStride = AW'(GridCells);
  localparam logic [AW-1:0] LastAddr  = AW'(Depth - 1);

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_TST} state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic [CW-1:0]   x_q, y_q;
  logic            done_q, hit_q;

  got_pkg::span_t  span_q;
  logic [GridCells-1:0] mask_q;
  logic [GridCells-1:0] rdata_q;
  logic [GridCells-1:0] mem [Depth];

  logic [AW-1:0]        addr;
  logic                 overlap;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [GridCells-1:0] mem_wdata;
  logic                 y_last, x_last;

  assign addr    = AW'(x_q) * RowStride + AW'(y_q);
  assign overlap = |(rdata_q & mask_q);
  assign y_last  = (y_q == span_q.ymx[CW-1:0]);
  assign x_last  = (x_q == span_q.xmx[CW-1:0]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = rdata_q | mask_q;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_TST: mem_we = !overlap;
      default: mem_we = 1'b0;
    endcase
  end

  // Cells of one span are distinct and each write lands before the next read,
  // so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LastAddr) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            x_q     <= span_i.xmn[CW-1:0];
            y_q     <= span_i.ymn[CW-1:0];
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_TST;
        S_TST: begin
          if (overlap) begin
            hit_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (!y_last) begin
            y_q     <= y_q + CW'(1);
            state_q <= S_RD;
          end else if (!x_last) begin
            x_q     <= x_q + CW'(1);
            y_q     <= span_q.ymn[CW-1:0];
            state_q <= S_RD;
          end else begin
            hit_q   <= 1'b0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      span_q <= span_i;
      mask_q <= (GridCells'(1) << span_i.zmn) | (GridCells'(1) << span_i.zmx);
    end
  end

  assign st_o = '{idle: (state_q == S_IDLE), done: done_q, hit: hit_q};

endmodule

@@ design/grid_occupancy_test_and_set.sv @@
// Top level of the grid occupancy test-and-set block.
// Each point is mapped to a clamped cell span, then up to four xy cells of the
// occupancy memory are tested and marked. The span unit is fed through a start
// register, then runs three axes through one shared 33x17 multiplier, five steps
// each; the walker loads the span, then for each visited cell reads the memory,
// then tests and writes back; the result then passes a pending flag into the
// output register, which raises out_valid_o. The next point can be taken once
// the result is loaded into the output register, which waits while the output
// is held off.
// Items are handled one at a time, but the next point is taken while a result
// still waits in the output register.
// After reset the memory is swept to zero, during which no point is taken;
// configuration writes are taken at any time.
`include "grid_occupancy_test_and_set_macros.svh"

module grid_occupancy_test_and_set #(
  parameter int unsigned GRID_CELLS = got_pkg::GRID_CELLS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [got_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [got_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [got_pkg::COORD_W-1:0]    point_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,
  input  logic                                  cfg_we_i,
  input  logic        [got_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic        [got_pkg::COORD_W-1:0]    cfg_data_i
);

  localparam logic [got_pkg::CELL_W-1:0] CellMax = got_pkg::CELL_W'(GRID_CELLS - 1);

  logic signed [got_pkg::COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic        [got_pkg::SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;
  logic        [got_pkg::CELL_W-1:0]  clamp_low_q, clamp_high_q;
  logic        [got_pkg::CELL_W-1:0]  lo_sat, hi_sat;

  logic signed [got_pkg::COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;

  logic busy_q, start_q, res_pend_q, res_hit_q, out_valid_q, hit_q;
  logic in_beat, out_load;

  logic              span_done;
  got_pkg::span_t    span;
  got_pkg::walk_st_t walk_st;

  assign in_stall_o = busy_q || !walk_st.idle;
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_load   = res_pend_q && (!out_valid_q || !out_stall_i);

  // Clamp limits beyond the grid are pulled back to the last cell.
  assign lo_sat = (clamp_low_q  > CellMax) ? CellMax : clamp_low_q;
  assign hi_sat = (clamp_high_q > CellMax) ? CellMax : clamp_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      origin_z_q   <= '0;
      scale_x_q    <= got_pkg::SCALE_RST;
      scale_y_q    <= got_pkg::SCALE_RST;
      scale_z_q    <= got_pkg::SCALE_RST;
      clamp_low_q  <= got_pkg::CLAMP_LOW_RST;
      clamp_high_q <= got_pkg::CLAMP_HIGH_RST;
    end else if (cfg_we_i) begin
      case (got_pkg::reg_idx_e'(cfg_index_i))
        got_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        got_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        got_pkg::REG_ORIGIN_Z:   origin_z_q   <= cfg_data_i;
        got_pkg::REG_SCALE_X:    scale_x_q    <= cfg_data_i[got_pkg::SCALE_W-1:0];
        got_pkg::REG_SCALE_Y:    scale_y_q    <= cfg_data_i[got_pkg::SCALE_W-1:0];
        got_pkg::REG_SCALE_Z:    scale_z_q    <= cfg_data_i[got_pkg::SCALE_W-1:0];
        got_pkg::REG_CLAMP_LOW:  clamp_low_q  <= cfg_data_i[got_pkg::CELL_W-1:0];
        got_pkg::REG_CLAMP_HIGH: clamp_high_q <= cfg_data_i[got_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      pt_x_q <= point_x_i;
      pt_y_q <= point_y_i;
      pt_z_q <= point_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      res_pend_q  <= 1'b0;
      res_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      start_q <= in_beat;
      if (in_beat) busy_q <= 1'b1;
      if (walk_st.done) begin
        res_pend_q <= 1'b1;
        res_hit_q  <= walk_st.hit;
      end
      if (out_load) begin
        res_pend_q  <= 1'b0;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
        hit_q       <= res_hit_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  got_span u_span (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .point_x_i  (pt_x_q),
    .point_y_i  (pt_y_q),
    .point_z_i  (pt_z_q),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .origin_z_i (origin_z_q),
    .scale_x_i  (scale_x_q),
    .scale_y_i  (scale_y_q),
    .scale_z_i  (scale_z_q),
    .lo_i       (lo_sat),
    .hi_i       (hi_sat),
    .done_o     (span_done),
    .span_o     (span)
  );

  got_walk #(
    .GridCells (GRID_CELLS)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (span_done),
    .span_i  (span),
    .st_o    (walk_st)
  );

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  `GOT_ASSERT(a_walk_idle_on_span, span_done |-> walk_st.idle)
  `GOT_ASSERT(a_result_while_busy, walk_st.done |-> (busy_q && !res_pend_q))
  `GOT_ASSERT(a_out_from_pending, $rose(out_valid_q) |-> $past(res_pend_q))
  `GOT_ASSERT_NEXT(a_beat_then_stall, in_beat, in_stall_o)

endmodule
